>>> src/window_sigma_anomaly_flagger_defines.svh
// Assertion macros for the checker file of this block.
`ifndef WINDOW_SIGMA_ANOMALY_FLAGGER_DEFINES_SVH
`define WINDOW_SIGMA_ANOMALY_FLAGGER_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define WSAF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds across reset.
`define WSAF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/wsaf_pkg.sv
package wsaf_pkg;

  localparam int WINDOW     = 16;
  localparam int VALUE_BITS = 24;
  localparam int THETA_W    = 12;
  localparam logic [THETA_W-1:0] THETA_RESET = 12'd768;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PSUM_W = VALUE_BITS + PTR_W + 1;     // running sum of values
  localparam int QSUM_W = 2 * VALUE_BITS + PTR_W;     // running sum of squares
  localparam int NM_W   = VALUE_BITS + CNT_W;         // n*m and d*n
  localparam int S_W    = 2 * VALUE_BITS + PTR_W + 1; // spread, nonnegative
  localparam int ACC_W  = S_W + 3;                    // signed spread accumulator
  localparam int SLO_W  = 32;                         // low slice of the spread
  localparam int SHI_W  = S_W - SLO_W;
  localparam int TT_W   = 2 * THETA_W;                // theta squared
  localparam int LHS_W  = 2 * VALUE_BITS + CNT_W;     // d*d*n
  localparam int LHS_SH = 16;                         // 2^16 scale of the left side
  localparam int RHS_W  = TT_W + S_W;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int IN_TDATA_W  = 2 * VALUE_BITS;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 1;

  // Multiplier operand selection
  localparam logic [3:0] MS_NONE   = 4'd0;
  localparam logic [3:0] MS_OLD_SQ = 4'd1;
  localparam logic [3:0] MS_NEW_SQ = 4'd2;
  localparam logic [3:0] MS_M_P    = 4'd3;
  localparam logic [3:0] MS_N_M    = 4'd4;
  localparam logic [3:0] MS_NM_M   = 4'd5;
  localparam logic [3:0] MS_TH_TH  = 4'd6;
  localparam logic [3:0] MS_D_N    = 4'd7;
  localparam logic [3:0] MS_DN_D   = 4'd8;
  localparam logic [3:0] MS_TT_SLO = 4'd9;
  localparam logic [3:0] MS_TT_SHI = 4'd10;

  typedef struct packed {
    logic       load;
    logic       ring_upd;
    logic       q_sub;
    logic       q_add;
    logic       acc_init;
    logic       acc_add;
    logic       tt_ld;
    logic       lhs_ld;
    logic       rhs_lo;
    logic       rhs_hi;
    logic       out_ld;
    logic [3:0] mul_sel;
  } cmd_t;

  typedef struct packed {
    logic eligible;
  } sts_t;

endpackage

>>> src/wsaf_mul.sv
module wsaf_mul (
  input  logic                                  clk,
  input  logic signed [wsaf_pkg::MUL_W-1:0]     a,
  input  logic signed [wsaf_pkg::MUL_W-1:0]     b,
  output logic signed [wsaf_pkg::PROD_W-1:0]    p_r
);

  // One signed product per cycle, registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> src/wsaf_dp.sv
module wsaf_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  wsaf_pkg::cmd_t                         cmd,
  output wsaf_pkg::sts_t                         sts,
  input  logic                                   in_restart,
  input  logic                                   in_present,
  input  logic signed [wsaf_pkg::VALUE_BITS-1:0] in_value,
  input  logic signed [wsaf_pkg::VALUE_BITS-1:0] in_mean,
  input  logic                                   cfg_wr_en,
  input  logic [wsaf_pkg::THETA_W-1:0]           cfg_wr_data,
  output logic                                   out_verdict,
  output logic                                   out_anomaly
);

  localparam int VB = wsaf_pkg::VALUE_BITS;
  localparam int MW = wsaf_pkg::MUL_W;

  logic [VB-1:0]                       ring_val [wsaf_pkg::WINDOW];
  logic [wsaf_pkg::WINDOW-1:0]         pres_r;
  logic [wsaf_pkg::PTR_W-1:0]          ptr_r;
  logic [wsaf_pkg::CNT_W-1:0]          fill_r;
  logic [wsaf_pkg::CNT_W-1:0]          cnt_r;
  logic [wsaf_pkg::PSUM_W-1:0]         psum_r;
  logic [wsaf_pkg::QSUM_W-1:0]         qsum_r;
  logic [VB-1:0]                       last_r;
  logic [wsaf_pkg::THETA_W-1:0]        theta_r;

  logic [VB-1:0]                       val_r;
  logic [VB-1:0]                       mean_r;
  logic                                present_r;
  logic [wsaf_pkg::ACC_W-1:0]          acc_r;
  logic [wsaf_pkg::TT_W-1:0]           tt_r;
  logic [wsaf_pkg::LHS_W-1:0]          lhs_r;
  logic [wsaf_pkg::RHS_W-1:0]          rhs_r;
  logic                                verdict_r;
  logic                                anomaly_r;

  logic                                old_p;
  logic [VB-1:0]                       old_v;
  logic [VB-1:0]                       new_v;
  logic [VB:0]                         diff;
  logic [VB:0]                         dmag;
  logic [VB-1:0]                       dabs;
  logic                                eligible;
  logic                                lhs_less;
  logic signed [MW-1:0]                mul_a;
  logic signed [MW-1:0]                mul_b;
  logic signed [wsaf_pkg::PROD_W-1:0]  prod_r;

  wsaf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign old_p    = pres_r[ptr_r];
  assign old_v    = old_p ? ring_val[ptr_r] : '0;
  assign new_v    = present_r ? val_r : '0;
  assign diff     = {last_r[VB-1], last_r} - {mean_r[VB-1], mean_r};
  assign dmag     = diff[VB] ? (~diff + 1'b1) : diff;
  assign dabs     = dmag[VB-1:0];
  assign eligible = (fill_r == wsaf_pkg::CNT_W'(wsaf_pkg::WINDOW)) && (cnt_r != '0);
  assign lhs_less = {(wsaf_pkg::RHS_W - wsaf_pkg::LHS_W - wsaf_pkg::LHS_SH)'(0),
                     lhs_r, wsaf_pkg::LHS_SH'(0)} < rhs_r;
  assign sts.eligible = eligible;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      wsaf_pkg::MS_OLD_SQ: begin
        mul_a = {{(MW-VB){old_v[VB-1]}}, old_v};
        mul_b = {{(MW-VB){old_v[VB-1]}}, old_v};
      end
      wsaf_pkg::MS_NEW_SQ: begin
        mul_a = {{(MW-VB){new_v[VB-1]}}, new_v};
        mul_b = {{(MW-VB){new_v[VB-1]}}, new_v};
      end
      wsaf_pkg::MS_M_P: begin
        mul_a = {{(MW-VB){mean_r[VB-1]}}, mean_r};
        mul_b = {{(MW-wsaf_pkg::PSUM_W){psum_r[wsaf_pkg::PSUM_W-1]}}, psum_r};
      end
      wsaf_pkg::MS_N_M: begin
        mul_a = {(MW-wsaf_pkg::CNT_W)'(0), cnt_r};
        mul_b = {{(MW-VB){mean_r[VB-1]}}, mean_r};
      end
      wsaf_pkg::MS_NM_M: begin
        mul_a = {{(MW-wsaf_pkg::NM_W){prod_r[wsaf_pkg::NM_W-1]}},
                 prod_r[wsaf_pkg::NM_W-1:0]};
        mul_b = {{(MW-VB){mean_r[VB-1]}}, mean_r};
      end
      wsaf_pkg::MS_TH_TH: begin
        mul_a = {(MW-wsaf_pkg::THETA_W)'(0), theta_r};
        mul_b = {(MW-wsaf_pkg::THETA_W)'(0), theta_r};
      end
      wsaf_pkg::MS_D_N: begin
        mul_a = {(MW-VB)'(0), dabs};
        mul_b = {(MW-wsaf_pkg::CNT_W)'(0), cnt_r};
      end
      wsaf_pkg::MS_DN_D: begin
        mul_a = {(MW-wsaf_pkg::NM_W)'(0), prod_r[wsaf_pkg::NM_W-1:0]};
        mul_b = {(MW-VB)'(0), dabs};
      end
      wsaf_pkg::MS_TT_SLO: begin
        mul_a = {(MW-wsaf_pkg::TT_W)'(0), tt_r};
        mul_b = {(MW-wsaf_pkg::SLO_W)'(0), acc_r[wsaf_pkg::SLO_W-1:0]};
      end
      wsaf_pkg::MS_TT_SHI: begin
        mul_a = {(MW-wsaf_pkg::TT_W)'(0), tt_r};
        mul_b = {(MW-wsaf_pkg::SHI_W)'(0), acc_r[wsaf_pkg::S_W-1:wsaf_pkg::SLO_W]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Window state and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r  <= '0;
      ptr_r   <= '0;
      fill_r  <= '0;
      cnt_r   <= '0;
      psum_r  <= '0;
      qsum_r  <= '0;
      last_r  <= '0;
      theta_r <= wsaf_pkg::THETA_RESET;
    end else begin
      if (cfg_wr_en) begin
        theta_r <= cfg_wr_data;
      end
      if (cmd.load && in_restart) begin
        pres_r <= '0;
        ptr_r  <= '0;
        fill_r <= '0;
        cnt_r  <= '0;
        psum_r <= '0;
        qsum_r <= '0;
        last_r <= '0;
      end
      if (cmd.ring_upd) begin
        pres_r[ptr_r] <= present_r;
        ptr_r  <= (ptr_r == wsaf_pkg::PTR_W'(wsaf_pkg::WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        if (fill_r != wsaf_pkg::CNT_W'(wsaf_pkg::WINDOW)) begin
          fill_r <= fill_r + 1'b1;
        end
        cnt_r  <= cnt_r - wsaf_pkg::CNT_W'(old_p) + wsaf_pkg::CNT_W'(present_r);
        psum_r <= psum_r - {{(wsaf_pkg::PSUM_W-VB){old_v[VB-1]}}, old_v}
                         + {{(wsaf_pkg::PSUM_W-VB){new_v[VB-1]}}, new_v};
        if (present_r) begin
          last_r <= val_r;
        end
      end
      if (cmd.q_sub) begin
        qsum_r <= qsum_r - prod_r[wsaf_pkg::QSUM_W-1:0];
      end
      if (cmd.q_add) begin
        qsum_r <= qsum_r + prod_r[wsaf_pkg::QSUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      ring_val[ptr_r] <= val_r;
    end
  end

  // Item fields and the verdict arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r     <= in_value;
      mean_r    <= in_mean;
      present_r <= in_present;
    end
    if (cmd.acc_init) begin
      acc_r <= wsaf_pkg::ACC_W'(qsum_r) - {prod_r[wsaf_pkg::ACC_W-2:0], 1'b0};
    end
    if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r[wsaf_pkg::ACC_W-1:0];
    end
    if (cmd.tt_ld) begin
      tt_r <= prod_r[wsaf_pkg::TT_W-1:0];
    end
    if (cmd.lhs_ld) begin
      lhs_r <= prod_r[wsaf_pkg::LHS_W-1:0];
    end
    if (cmd.rhs_lo) begin
      rhs_r <= wsaf_pkg::RHS_W'(prod_r[wsaf_pkg::SLO_W+wsaf_pkg::TT_W-1:0]);
    end
    if (cmd.rhs_hi) begin
      rhs_r <= rhs_r + {prod_r[wsaf_pkg::RHS_W-wsaf_pkg::SLO_W-1:0],
                        wsaf_pkg::SLO_W'(0)};
    end
    if (cmd.out_ld) begin
      verdict_r <= eligible;
      anomaly_r <= eligible && !lhs_less;
    end
  end

  assign out_verdict = verdict_r;
  assign out_anomaly = anomaly_r;

endmodule

>>> src/wsaf_ctrl.sv
module wsaf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output wsaf_pkg::cmd_t cmd,
  input  wsaf_pkg::sts_t sts
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_OLD  = 4'd1;
  localparam logic [3:0] ST_NEW  = 4'd2;
  localparam logic [3:0] ST_ADDQ = 4'd3;
  localparam logic [3:0] ST_MP   = 4'd4;
  localparam logic [3:0] ST_NM   = 4'd5;
  localparam logic [3:0] ST_NMM  = 4'd6;
  localparam logic [3:0] ST_TT   = 4'd7;
  localparam logic [3:0] ST_DN   = 4'd8;
  localparam logic [3:0] ST_LHS  = 4'd9;
  localparam logic [3:0] ST_RLO  = 4'd10;
  localparam logic [3:0] ST_RHI  = 4'd11;
  localparam logic [3:0] ST_CMP  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_OLD;
        end
      end
      ST_OLD: begin
        cmd.ring_upd = 1'b1;
        cmd.mul_sel  = wsaf_pkg::MS_OLD_SQ;
        state_nxt    = ST_NEW;
      end
      ST_NEW: begin
        cmd.q_sub   = 1'b1;
        cmd.mul_sel = wsaf_pkg::MS_NEW_SQ;
        state_nxt   = ST_ADDQ;
      end
      ST_ADDQ: begin
        cmd.q_add   = 1'b1;
        cmd.mul_sel = wsaf_pkg::MS_M_P;
        state_nxt   = sts.eligible ? ST_MP : ST_CMP;
      end
      ST_MP: begin
        cmd.acc_init = 1'b1;
        cmd.mul_sel  = wsaf_pkg::MS_N_M;
        state_nxt    = ST_NM;
      end
      ST_NM: begin
        cmd.mul_sel = wsaf_pkg::MS_NM_M;
        state_nxt   = ST_NMM;
      end
      ST_NMM: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = wsaf_pkg::MS_TH_TH;
        state_nxt   = ST_TT;
      end
      ST_TT: begin
        cmd.tt_ld   = 1'b1;
        cmd.mul_sel = wsaf_pkg::MS_D_N;
        state_nxt   = ST_DN;
      end
      ST_DN: begin
        cmd.mul_sel = wsaf_pkg::MS_DN_D;
        state_nxt   = ST_LHS;
      end
      ST_LHS: begin
        cmd.lhs_ld  = 1'b1;
        cmd.mul_sel = wsaf_pkg::MS_TT_SLO;
        state_nxt   = ST_RLO;
      end
      ST_RLO: begin
        cmd.rhs_lo  = 1'b1;
        cmd.mul_sel = wsaf_pkg::MS_TT_SHI;
        state_nxt   = ST_RHI;
      end
      ST_RHI: begin
        cmd.rhs_hi = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

>>> src/window_sigma_anomaly_flagger.sv
// Steps: a word with a verdict goes through the window update, the sums of squares,
//   the spread and the squared test; a word without one (window not full or no
//   present sample) goes from the sums straight to the compare. A new word is taken
//   only once the last is through; the single shared 33x33 multiplier runs every step.
// Reset: synchronous, active low; clears the window, sums and output valid,
//   and sets theta_q8 to 768 (3.0).
module window_sigma_anomaly_flagger (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wsaf_pkg::IN_TDATA_W-1:0]     in_tdata,   // [23:0] sample_value, [47:24] window_mean
  input  logic [wsaf_pkg::IN_TUSER_W-1:0]     in_tuser,   // [0] restart, [1] sample_present
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wsaf_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] is_anomaly, [7:1] zero
  output logic [wsaf_pkg::OUT_TUSER_W-1:0]    out_tuser,  // [0] verdict_valid
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [wsaf_pkg::THETA_W-1:0]        cfg_wr_data // theta_q8
);

  localparam int VB = wsaf_pkg::VALUE_BITS;

  wsaf_pkg::cmd_t cmd;
  wsaf_pkg::sts_t sts;
  logic           verdict;
  logic           anomaly;

  // The controller walks each word through its steps: window update, removal and
  // addition of squares, then the spread S = Q - 2mP + n*m^2 and the test
  // (v-m)^2 * n * 2^16 < theta^2 * S, one multiplier product per cycle.
  // Accept the next word as soon as the previous verdict is parked in the
  // output register, even if the sink has not taken it yet.
  wsaf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // The datapath holds the sample ring with its present bits, the running sum of
  // present values and of their squares, counts, last present value and theta.
  // A restart word clears that state, theta apart, at acceptance and then enters as
  // the first sample of a new stream.
  wsaf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_restart  (in_tuser[0]),
    .in_present  (in_tuser[1]),
    .in_value    (in_tdata[VB-1:0]),
    .in_mean     (in_tdata[2*VB-1:VB]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_verdict (verdict),
    .out_anomaly (anomaly)
  );

  // Pack the verdict; the flag is zero whenever no verdict is given.
  assign out_tdata = wsaf_pkg::OUT_TDATA_W'(anomaly);
  assign out_tuser = verdict;

endmodule

>>> src/wsaf_checker.sv
`include "window_sigma_anomaly_flagger_defines.svh"

module wsaf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wsaf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [wsaf_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result keeps its payload.
  `WSAF_ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // No anomaly flag without a verdict.
  `WSAF_ASSERT_CLK(a_flag_needs_verdict, clk, rst_n, out_tvalid |-> !(out_tdata[0] && !out_tuser[0]), "anomaly flagged without verdict")

  // One word in work at a time: input closes right after an acceptance.
  `WSAF_ASSERT_CLK(a_one_in_flight, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input accepted while busy")

  // Reset empties the output register.
  `WSAF_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind window_sigma_anomaly_flagger wsaf_checker u_wsaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> sim/window_sigma_anomaly_flagger_tb.sv
module window_sigma_anomaly_flagger_tb;

  localparam int VB = wsaf_pkg::VALUE_BITS;
  // The left side of the squared test carries a 2^16 scale (theta is Q4.8, squared).
  localparam int THETA_SQ_FRAC = 16;

  // One input word as the generator sees it: restart, present, value, mean.
  typedef struct packed {
    logic          restart;
    logic          present;
    logic [VB-1:0] value;
    logic [VB-1:0] mean;
  } sample_word_t;

  typedef struct packed {
    logic verdict_valid;
    logic is_anomaly;
  } verdict_t;

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_tvalid   = 1'b0;
  logic                             in_tready;
  logic [wsaf_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;  // [23:0] sample_value, [47:24] window_mean
  logic [wsaf_pkg::IN_TUSER_W-1:0]  in_tuser    = '0;  // [0] restart, [1] sample_present
  logic                             out_tvalid;
  logic                             out_tready  = 1'b0;
  logic [wsaf_pkg::OUT_TDATA_W-1:0] out_tdata;         // [0] is_anomaly, [7:1] zero
  logic [wsaf_pkg::OUT_TUSER_W-1:0] out_tuser;         // [0] verdict_valid
  logic                             cfg_wr_en   = 1'b0;
  logic [wsaf_pkg::THETA_W-1:0]     cfg_wr_data = '0;  // theta_q8

  sample_word_t pending_words[$];  // words waiting for the driver
  verdict_t     verdict_q[$];      // predicted verdicts, oldest first
  sample_word_t drive_word;
  verdict_t     wanted;
  int           mismatches = 0;
  int           idle_pct   = 0;    // chance that a stall burst starts: percent per input word, per 400 on output
  int           in_gap     = 0;
  int           out_gap    = 0;

  // Shadow copy of the window, the counters and the threshold.
  logic                         win_present [wsaf_pkg::WINDOW];
  logic signed [VB-1:0]         win_value   [wsaf_pkg::WINDOW];
  int                           win_ptr;
  int                           win_fill;
  int                           win_npresent;
  logic signed [VB-1:0]         last_value;
  logic [wsaf_pkg::THETA_W-1:0] theta;

  window_sigma_anomaly_flagger dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Empty the window: used at reset and on a restart word.
  task automatic clear_window();
    for (int i = 0; i < wsaf_pkg::WINDOW; i++) begin
      win_present[i] = 1'b0;
      win_value[i]   = '0;
    end
    win_ptr      = 0;
    win_fill     = 0;
    win_npresent = 0;
    last_value   = '0;
  endtask

  // Advance the shadow window by one accepted word and queue the verdict it yields.
  // The squared test is done in 128 bits, wide enough that nothing wraps:
  // (v-m)^2 * n * 2^16 < theta^2 * sum((x-m)^2) means normal.
  task automatic predict_verdict(input sample_word_t w);
    logic [127:0]         spread;
    logic [127:0]         mag;
    logic [127:0]         lhs;
    logic [127:0]         rhs;
    logic signed [VB+1:0] diff;
    verdict_t             v;
    if (w.restart) clear_window();
    // drop the slot being overwritten from the present count
    if (win_present[win_ptr] && win_npresent > 0) win_npresent--;
    win_present[win_ptr] = w.present;
    win_value[win_ptr]   = w.present ? w.value : '0;
    if (w.present) begin
      win_npresent++;
      last_value = w.value;
    end
    win_ptr = (win_ptr + 1) % wsaf_pkg::WINDOW;
    if (win_fill < wsaf_pkg::WINDOW) win_fill++;
    v = '0;
    if (win_fill >= wsaf_pkg::WINDOW && win_npresent > 0) begin
      spread = '0;
      for (int i = 0; i < wsaf_pkg::WINDOW; i++) begin
        if (win_present[i]) begin
          diff   = win_value[i] - $signed(w.mean);
          mag    = 128'(diff < 0 ? -diff : diff);
          spread = spread + mag * mag;
        end
      end
      diff = last_value - $signed(w.mean);
      mag  = 128'(diff < 0 ? -diff : diff);
      lhs  = (mag * mag * 128'(win_npresent)) << THETA_SQ_FRAC;
      rhs  = 128'(theta) * 128'(theta) * spread;
      v.verdict_valid = 1'b1;
      // strict test: zero spread or zero threshold always flags
      v.is_anomaly    = !(lhs < rhs);
    end
    verdict_q.push_back(v);
  endtask

  task automatic push_word(input logic restart, input logic present,
                           input logic [VB-1:0] value, input logic [VB-1:0] mean);
    sample_word_t w;
    w.restart = restart;
    w.present = present;
    w.value   = value;
    w.mean    = mean;
    pending_words.push_back(w);
  endtask

  // One sensor stream: restart, then samples scattered around a center with a
  // mean close to it, some missing, some pushed far out.
  task automatic queue_stream(input int len);
    int center;
    int span;
    int shift;
    int missing_pct;
    int outlier_pct;
    int v;
    int m;
    center = int'($urandom_range(16777215)) - 8388608;
    center = center >>> $urandom_range(0, 16);
    shift  = $urandom_range(0, 20);
    // span zero gives a flat stream: zero spread on every verdict
    span        = (shift == 0) ? 0 : (1 << (shift - 1));
    missing_pct = $urandom_range(0, 30);
    outlier_pct = $urandom_range(0, 15);
    for (int k = 0; k < len; k++) begin
      v = center + int'($urandom_range(2 * span)) - span;
      if ($urandom_range(99) < outlier_pct)
        v += ($urandom_range(1) ? 1 : -1) * span * int'($urandom_range(2, 8));
      m = center + int'($urandom_range(span / 2)) - span / 4;
      // rare restart in the middle breaks a stream
      push_word(k == 0 || $urandom_range(199) == 0, $urandom_range(99) >= missing_pct,
                v[VB-1:0], m[VB-1:0]);
    end
  endtask

  // Hold until every word is sent and every verdict has come back.
  task automatic wait_drained();
    while (pending_words.size() > 0 || in_tvalid || verdict_q.size() > 0)
      @(posedge clk);
  endtask

  // Write theta only while the block is idle; let the back end settle first.
  task automatic set_theta(input logic [wsaf_pkg::THETA_W-1:0] t);
    wait_drained();
    repeat (16) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    theta = t;
  endtask

  // Driver: predict on each accepted word, then present the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_verdict(sample_word_t'({in_tuser[0], in_tuser[1],
                                        in_tdata[VB-1:0], in_tdata[2*VB-1:VB]}));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          drive_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {drive_word.mean, drive_word.value};
          in_tuser  <= {drive_word.present, drive_word.restart};
          if ($urandom_range(99) < idle_pct) in_gap = $urandom_range(1, 12);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: verdict_valid=%b is_anomaly=%b",
                     out_tuser[0], out_tdata[0]);
        end else begin
          wanted = verdict_q.pop_front();
          if (out_tuser[0] !== wanted.verdict_valid || out_tdata[0] !== wanted.is_anomaly) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict mismatch: expected valid=%b anomaly=%b, got valid=%b anomaly=%b",
                       wanted.verdict_valid, wanted.is_anomaly, out_tuser[0], out_tdata[0]);
          end
        end
      end
      // stall bursts start per cycle, so keep the chance low
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(399) < idle_pct) out_gap = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    logic [wsaf_pkg::THETA_W-1:0] theta_plan [6];
    int                           idle_plan  [6];
    int                           count;
    int                           n;
    int                           len;
    clear_window();
    theta = wsaf_pkg::THETA_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold.
    idle_pct = 25;
    set_theta(wsaf_pkg::THETA_RESET);
    // full window of missing samples: no verdict
    push_word(1'b1, 1'b0, 24'h5a5a5a, 24'h000000);
    repeat (wsaf_pkg::WINDOW - 1) push_word(1'b0, 1'b0, VB'($urandom), VB'($urandom));
    // single present sample equal to the mean: zero spread, flagged
    push_word(1'b0, 1'b1, 24'h123456, 24'h123456);
    // extremes of value and mean
    push_word(1'b0, 1'b1, 24'h7fffff, 24'h800000);
    push_word(1'b0, 1'b1, 24'h800000, 24'h7fffff);
    // missing sample: verdict on the last present value
    push_word(1'b0, 1'b0, 24'hffffff, 24'h000000);
    push_word(1'b0, 1'b1, 24'h000000, 24'h000000);
    // restart with a sample: window not full again
    push_word(1'b1, 1'b1, 24'h800000, 24'h800000);
    push_word(1'b0, 1'b1, 24'h000100, 24'h000080);

    // Random phases: threshold extremes first, no idling in the last one.
    theta_plan = '{12'd0, 12'd4095, 12'd256, 12'd0, 12'd0, wsaf_pkg::THETA_RESET};
    theta_plan[3] = wsaf_pkg::THETA_W'($urandom_range(1, 4094));
    theta_plan[4] = wsaf_pkg::THETA_W'($urandom_range(1, 4094));
    idle_plan  = '{30, 0, 60, 20, 45, 0};
    for (int p = 0; p < 6; p++) begin
      idle_pct = idle_plan[p];
      set_theta(theta_plan[p]);
      count = 0;
      while (count < 220) begin
        if ($urandom_range(99) < 15) begin
          // noise: any bit pattern, occasional restart
          n = $urandom_range(1, 8);
          repeat (n) push_word($urandom_range(99) < 5, 1'($urandom_range(1)),
                               VB'($urandom), VB'($urandom));
          count += n;
        end else begin
          len = $urandom_range(wsaf_pkg::WINDOW, 4 * wsaf_pkg::WINDOW);
          queue_stream(len);
          count += len;
        end
      end
    end

    wait_drained();
    // catch any stray result word behind the last verdict
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/wsaf_pkg.sv
src/wsaf_mul.sv
src/wsaf_dp.sv
src/wsaf_ctrl.sv
src/window_sigma_anomaly_flagger.sv
src/wsaf_checker.sv
sim/window_sigma_anomaly_flagger_tb.sv
